// ===== design/tcprx_pkg.sv =====
package tcprx_pkg;

  // telnet command bytes
  localparam logic [7:0] T_IAC  = 8'd255;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_SE   = 8'd240;

  // com port option and server response codes
  localparam logic [7:0] COM_PORT_OPT = 8'd44;
  localparam logic [7:0] SRV_OFFSET   = 8'd100;
  localparam logic [7:0] SRV_BAUD     = SRV_OFFSET + 8'd1;
  localparam logic [7:0] SRV_DATASIZE = SRV_OFFSET + 8'd2;
  localparam logic [7:0] SRV_PARITY   = SRV_OFFSET + 8'd3;
  localparam logic [7:0] SRV_STOPSIZE = SRV_OFFSET + 8'd4;
  localparam logic [7:0] SRV_CONTROL  = SRV_OFFSET + 8'd5;
  localparam logic [7:0] SRV_LINE     = SRV_OFFSET + 8'd6;
  localparam logic [7:0] SRV_MODEM    = SRV_OFFSET + 8'd7;
  localparam logic [7:0] SRV_SUSPEND  = SRV_OFFSET + 8'd8;
  localparam logic [7:0] SRV_RESUME   = SRV_OFFSET + 8'd9;
  localparam logic [7:0] SRV_LSMASK   = SRV_OFFSET + 8'd10;
  localparam logic [7:0] SRV_MSMASK   = SRV_OFFSET + 8'd11;
  localparam logic [7:0] SRV_PURGE    = SRV_OFFSET + 8'd12;

  // plain characters
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // input command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // result kinds
  typedef enum logic [3:0] {
    KIND_DATA   = 4'd0,
    KIND_WILL   = 4'd1,
    KIND_DO     = 4'd2,
    KIND_REFUSE = 4'd3,
    KIND_ACK    = 4'd4,
    KIND_LINE   = 4'd5,
    KIND_MODEM  = 4'd6,
    KIND_FLOW   = 4'd7,
    KIND_ERROR  = 4'd8
  } kind_t;

  // acknowledged serial command codes
  localparam logic [3:0] ACK_NONE     = 4'd0;
  localparam logic [3:0] ACK_BAUD     = 4'd1;
  localparam logic [3:0] ACK_DATASIZE = 4'd2;
  localparam logic [3:0] ACK_PARITY   = 4'd3;
  localparam logic [3:0] ACK_STOPSIZE = 4'd4;
  localparam logic [3:0] ACK_CONTROL  = 4'd5;
  localparam logic [3:0] ACK_LSMASK   = 4'd10;
  localparam logic [3:0] ACK_MSMASK   = 4'd11;
  localparam logic [3:0] ACK_PURGE    = 4'd12;

  // one word held in the input stage
  typedef struct packed {
    logic       valid;
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  // one result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value_byte;
    logic [3:0]  ack_code;
    logic [31:0] baud_value;
    logic        write_enabled;
  } res_t;

  // parser status toward the output register
  typedef struct packed {
    logic fire;
    logic standby;
    res_t res;
  } par_out_t;

endpackage

// ===== design/tcprx_in_stage.sv =====
module tcprx_in_stage import tcprx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       advance,
  output item_t      item
);

  logic       valid_r;
  logic       cmd_r;
  logic [7:0] byte_r;

  // hold the word while the parser cannot move it on
  assign in_stall = valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r  <= in_cmd;
      byte_r <= in_rx_byte;
    end
  end

  assign item = '{valid: valid_r, cmd: cmd_r, rx_byte: byte_r};

endmodule

// ===== design/tcprx_parser.sv =====
module tcprx_parser import tcprx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  item_t    item,
  input  logic     take,
  output par_out_t pout
);

  typedef enum logic [22:0] {
    PS_STANDBY    = (23'd1 << 0),
    PS_STARTED    = (23'd1 << 1),
    PS_CR         = (23'd1 << 2),
    PS_IAC        = (23'd1 << 3),
    PS_WILL       = (23'd1 << 4),
    PS_WONT       = (23'd1 << 5),
    PS_DO         = (23'd1 << 6),
    PS_DONT       = (23'd1 << 7),
    PS_SB         = (23'd1 << 8),
    PS_UNREC      = (23'd1 << 9),
    PS_SE         = (23'd1 << 10),
    PS_SERIAL_CMD = (23'd1 << 11),
    PS_BAUD       = (23'd1 << 12),
    PS_DATASIZE   = (23'd1 << 13),
    PS_PARITY     = (23'd1 << 14),
    PS_STOPSIZE   = (23'd1 << 15),
    PS_CONTROL    = (23'd1 << 16),
    PS_LINESTATE  = (23'd1 << 17),
    PS_MODEMSTATE = (23'd1 << 18),
    PS_LSMASK     = (23'd1 << 19),
    PS_MSMASK     = (23'd1 << 20),
    PS_PURGE      = (23'd1 << 21),
    PS_END_SERIAL = (23'd1 << 22)
  } state_t;

  state_t      state_r, state_nxt;
  logic        crq_r, crq_nxt;
  logic        mw_r, mw_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        skip_r, skip_nxt;

  logic        fire;
  kind_t       kind;
  logic [7:0]  val;
  logic [3:0]  ack;
  logic [31:0] baud;
  logic [7:0]  b;
  state_t      sc_state;
  logic [1:0]  cnt_inc;

  assign b       = item.rx_byte;
  assign cnt_inc = cnt_r + 2'd1;

  // state entered on a serial command code
  always_comb begin
    case (b)
      SRV_BAUD:     sc_state = PS_BAUD;
      SRV_DATASIZE: sc_state = PS_DATASIZE;
      SRV_PARITY:   sc_state = PS_PARITY;
      SRV_STOPSIZE: sc_state = PS_STOPSIZE;
      SRV_CONTROL:  sc_state = PS_CONTROL;
      SRV_LINE:     sc_state = PS_LINESTATE;
      SRV_MODEM:    sc_state = PS_MODEMSTATE;
      SRV_SUSPEND:  sc_state = PS_END_SERIAL;
      SRV_RESUME:   sc_state = PS_END_SERIAL;
      SRV_LSMASK:   sc_state = PS_LSMASK;
      SRV_MSMASK:   sc_state = PS_MSMASK;
      SRV_PURGE:    sc_state = PS_PURGE;
      default:      sc_state = PS_UNREC;
    endcase
  end

  // one byte step of the parser
  always_comb begin
    state_nxt = state_r;
    crq_nxt   = crq_r;
    mw_nxt    = mw_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    fire      = 1'b0;
    kind      = KIND_DATA;
    val       = b;
    ack       = ACK_NONE;
    baud      = 32'd0;

    if (item.cmd == CMD_START) begin
      state_nxt = PS_STARTED;
      crq_nxt   = 1'b1;
      mw_nxt    = 1'b1;
      shift_nxt = 32'd0;
      cnt_nxt   = 2'd0;
      skip_nxt  = 1'b0;
    end else if (skip_r) begin
      // byte after a quoted mask value
      skip_nxt = 1'b0;
    end else begin
      case (state_r)
        PS_STARTED: begin
          if (b == T_IAC) begin
            state_nxt = PS_IAC;
          end else begin
            if (b == CH_CR) state_nxt = PS_CR;
            fire = 1'b1;
          end
        end
        PS_CR: begin
          state_nxt = PS_STARTED;
          if (b == CH_NUL && crq_r) begin
            fire = 1'b0;
          end else if (b == T_IAC) begin
            state_nxt = PS_IAC;
          end else begin
            if (b != CH_LF) crq_nxt = 1'b0;
            fire = 1'b1;
          end
        end
        PS_IAC: begin
          case (b)
            T_WILL: state_nxt = PS_WILL;
            T_WONT: state_nxt = PS_WONT;
            T_DO:   state_nxt = PS_DO;
            T_DONT: state_nxt = PS_DONT;
            T_SB:   state_nxt = PS_SB;
            T_SE:   state_nxt = PS_STARTED;
            T_IAC: begin
              state_nxt = PS_STARTED;
              fire      = 1'b1;
            end
            default: begin
              state_nxt = PS_STANDBY;
              skip_nxt  = 1'b0;
              cnt_nxt   = 2'd0;
              fire      = 1'b1;
              kind      = KIND_ERROR;
            end
          endcase
        end
        PS_WILL: begin
          state_nxt = PS_STARTED;
          fire      = 1'b1;
          kind      = KIND_WILL;
        end
        PS_DO: begin
          state_nxt = PS_STARTED;
          fire      = 1'b1;
          kind      = KIND_DO;
        end
        PS_WONT, PS_DONT: begin
          state_nxt = PS_STARTED;
          fire      = 1'b1;
          kind      = KIND_REFUSE;
        end
        PS_SB: begin
          state_nxt = (b == COM_PORT_OPT) ? PS_SERIAL_CMD : PS_UNREC;
        end
        PS_UNREC: begin
          if (b == T_IAC) state_nxt = PS_SE;
        end
        PS_SE: begin
          if (b == T_IAC) begin
            state_nxt = PS_UNREC;
          end else if (b == T_SE) begin
            state_nxt = PS_STARTED;
          end else begin
            state_nxt = PS_STANDBY;
            skip_nxt  = 1'b0;
            cnt_nxt   = 2'd0;
            fire      = 1'b1;
            kind      = KIND_ERROR;
          end
        end
        PS_SERIAL_CMD, PS_END_SERIAL: begin
          if (state_r == PS_END_SERIAL && b == T_IAC) begin
            state_nxt = PS_SE;
          end else begin
            state_nxt = sc_state;
            if (b == SRV_BAUD) begin
              cnt_nxt   = 2'd0;
              shift_nxt = 32'd0;
            end
            if (b == SRV_SUSPEND || b == SRV_RESUME) begin
              mw_nxt = (b == SRV_RESUME);
              fire   = 1'b1;
              kind   = KIND_FLOW;
            end
          end
        end
        PS_BAUD: begin
          // big-endian baud rate, four bytes
          shift_nxt = {shift_r[23:0], b};
          cnt_nxt   = cnt_inc;
          if (cnt_inc == 2'd0) begin
            state_nxt = PS_END_SERIAL;
            fire      = 1'b1;
            kind      = KIND_ACK;
            val       = 8'd0;
            ack       = ACK_BAUD;
            baud      = {shift_r[23:0], b};
          end
        end
        PS_DATASIZE, PS_PARITY, PS_STOPSIZE, PS_CONTROL, PS_PURGE: begin
          state_nxt = PS_END_SERIAL;
          fire      = 1'b1;
          kind      = KIND_ACK;
          case (state_r)
            PS_DATASIZE: ack = ACK_DATASIZE;
            PS_PARITY:   ack = ACK_PARITY;
            PS_STOPSIZE: ack = ACK_STOPSIZE;
            PS_CONTROL:  ack = ACK_CONTROL;
            default:     ack = ACK_PURGE;
          endcase
        end
        PS_LINESTATE: begin
          state_nxt = PS_END_SERIAL;
          fire      = 1'b1;
          kind      = KIND_LINE;
        end
        PS_MODEMSTATE: begin
          state_nxt = PS_END_SERIAL;
          fire      = 1'b1;
          kind      = KIND_MODEM;
        end
        PS_LSMASK, PS_MSMASK: begin
          // an iac mask value is quoted, drop its second byte
          state_nxt = PS_END_SERIAL;
          if (b == T_IAC) skip_nxt = 1'b1;
          fire = 1'b1;
          kind = KIND_ACK;
          ack  = (state_r == PS_LSMASK) ? ACK_LSMASK : ACK_MSMASK;
        end
        default: begin
          // standby drops bytes
          fire = 1'b0;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_STANDBY;
      crq_r   <= 1'b1;
      mw_r    <= 1'b1;
      shift_r <= 32'd0;
      cnt_r   <= 2'd0;
      skip_r  <= 1'b0;
    end else if (take) begin
      state_r <= state_nxt;
      crq_r   <= crq_nxt;
      mw_r    <= mw_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
    end
  end

  assign pout.fire    = fire;
  assign pout.standby = (state_r == PS_STANDBY);
  assign pout.res     = '{kind: kind, value_byte: val, ack_code: ack,
                          baud_value: baud, write_enabled: mw_nxt};

endmodule

// ===== design/telnet_com_port_rx_decoder_unit.sv =====
// Telnet com port receive parser: takes one received byte word (or a start
// word) per clock and returns at most one result word for it: data bytes
// with IAC doubling and CR NUL removed, option negotiations, decoded server
// serial responses, flow changes and protocol errors. A word is accepted in
// every cycle in which the output side keeps up. The accepting edge loads it
// into the input register; the combinational parse step feeds the result
// register, which takes the result once the output side is free. After reset
// the parser is in standby and drops bytes until a start word arrives.
module telnet_com_port_rx_decoder_unit import tcprx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_value_byte,
  output logic [3:0]  out_ack_code,
  output logic [31:0] out_baud_value,
  output logic        out_write_enabled
);

  item_t    item;
  par_out_t pout;
  logic     out_free;
  logic     take;
  logic     load;
  logic     out_valid_r;
  res_t     res_r;

  assign out_free = !out_valid_r || !out_stall;
  assign take     = item.valid && out_free;
  assign load     = take && pout.fire;

  // input register
  tcprx_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .advance    (out_free),
    .item       (item)
  );

  // parse step and parser state
  tcprx_parser u_par (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .take  (take),
    .pout  (pout)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= pout.res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_r.kind;
  assign out_value_byte    = res_r.value_byte;
  assign out_ack_code      = res_r.ack_code;
  assign out_baud_value    = res_r.baud_value;
  assign out_write_enabled = res_r.write_enabled;

  // a protocol error leaves the parser in standby
  a_err_standby: assert property (@(posedge clk) disable iff (!rst_n)
    (load && pout.res.kind == KIND_ERROR) |=> pout.standby)
    else $error("parser not in standby after protocol error");

  // flow results carry the matching write permission
  a_flow_perm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_FLOW) |->
      (out_write_enabled == (out_value_byte == SRV_RESUME)))
    else $error("flow result write permission mismatch");

  // a baud ack is an ack word with a zero value byte
  a_baud_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ack_code == ACK_BAUD) |->
      (out_kind == KIND_ACK && out_value_byte == 8'd0))
    else $error("malformed baud ack");

  // the input stage stalls only while it holds a word
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item.valid && out_valid_r && out_stall))
    else $error("input stall without a blocked word");

endmodule

// ===== bench/tb_telnet_com_port_rx_decoder_unit.sv =====
module tb_telnet_com_port_rx_decoder_unit import tcprx_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM       = 450;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;

  localparam res_t NO_RES = '0;

  // parser states of the predictor
  typedef enum {
    S_STANDBY, S_DATA, S_CR, S_IAC, S_WILL, S_WONT, S_DO, S_DONT, S_SB,
    S_SKIP, S_SKIP_IAC, S_SER_CMD, S_BAUD, S_DATASIZE, S_PARITY, S_STOPSIZE,
    S_CONTROL, S_LINE, S_MODEM, S_LSMASK, S_MSMASK, S_PURGE, S_SER_END
  } rx_state_t;

  // one row of the directed table
  typedef struct {
    logic       cmd;
    logic [7:0] rx_byte;
    bit         typed;
    bit         fire;
    res_t       res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_kind;
  logic [7:0]  out_value_byte;
  logic [3:0]  out_ack_code;
  logic [31:0] out_baud_value;
  logic        out_write_enabled;

  // predictor state
  rx_state_t   rx_state  = S_STANDBY;
  bit          cr_quote  = 1'b1;
  bit          may_write = 1'b1;
  logic [31:0] baud_acc  = '0;
  logic [1:0]  baud_cnt  = '0;
  bit          drop_next = 1'b0;

  res_t pending_results[$];
  int   rx_mismatches = 0;
  int   n_items       = 0;
  int   quiet_cycles  = 0;
  bit   in_calm       = 1'b0;
  int   in_calm_left  = 30;
  bit   out_calm      = 1'b0;
  int   out_calm_left = 40;
  int   stall_left    = 0;

  telnet_com_port_rx_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_value_byte   (out_value_byte),
    .out_ack_code     (out_ack_code),
    .out_baud_value   (out_baud_value),
    .out_write_enabled(out_write_enabled)
  );

  always #5 clk = ~clk;

  function automatic res_t make_res(kind_t k, logic [7:0] v, logic [3:0] a, logic [31:0] bd);
    res_t r;
    r.kind          = k;
    r.value_byte    = v;
    r.ack_code      = a;
    r.baud_value    = bd;
    r.write_enabled = may_write;
    return r;
  endfunction

  // protocol error: report the byte and fall back to standby
  function automatic void proto_fault(input logic [7:0] b, output bit fire, output res_t r);
    rx_state  = S_STANDBY;
    drop_next = 1'b0;
    baud_cnt  = '0;
    fire      = 1'b1;
    r         = make_res(KIND_ERROR, b, ACK_NONE, '0);
  endfunction

  // serial response code after the com port option or a finished response
  function automatic void take_serial_code(input logic [7:0] b, output bit fire,
                                           output res_t r);
    fire     = 1'b0;
    r        = NO_RES;
    rx_state = S_SKIP;
    case (b)
      SRV_BAUD: begin
        rx_state = S_BAUD;
        baud_cnt = '0;
        baud_acc = '0;
      end
      SRV_DATASIZE: rx_state = S_DATASIZE;
      SRV_PARITY:   rx_state = S_PARITY;
      SRV_STOPSIZE: rx_state = S_STOPSIZE;
      SRV_CONTROL:  rx_state = S_CONTROL;
      SRV_LINE:     rx_state = S_LINE;
      SRV_MODEM:    rx_state = S_MODEM;
      SRV_SUSPEND, SRV_RESUME: begin
        may_write = (b == SRV_RESUME);
        rx_state  = S_SER_END;
        fire      = 1'b1;
        r         = make_res(KIND_FLOW, b, ACK_NONE, '0);
      end
      SRV_LSMASK:   rx_state = S_LSMASK;
      SRV_MSMASK:   rx_state = S_MSMASK;
      SRV_PURGE:    rx_state = S_PURGE;
      default:      rx_state = S_SKIP;
    endcase
  endfunction

  // expected result of one accepted word
  function automatic void predict_rx(input logic c, input logic [7:0] b, output bit fire,
                                     output res_t r);
    fire = 1'b0;
    r    = NO_RES;
    if (c == CMD_START) begin
      rx_state  = S_DATA;
      cr_quote  = 1'b1;
      may_write = 1'b1;
      baud_acc  = '0;
      baud_cnt  = '0;
      drop_next = 1'b0;
      return;
    end
    // byte after a quoted mask value is dropped
    if (drop_next) begin
      drop_next = 1'b0;
      return;
    end
    case (rx_state)
      S_DATA: begin
        if (b == T_IAC) begin
          rx_state = S_IAC;
        end else begin
          if (b == CH_CR) rx_state = S_CR;
          fire = 1'b1;
          r    = make_res(KIND_DATA, b, ACK_NONE, '0);
        end
      end
      S_CR: begin
        rx_state = S_DATA;
        if (b == T_IAC) begin
          rx_state = S_IAC;
        end else if (!(b == CH_NUL && cr_quote)) begin
          if (b != CH_LF) cr_quote = 1'b0;
          fire = 1'b1;
          r    = make_res(KIND_DATA, b, ACK_NONE, '0);
        end
      end
      S_IAC: begin
        case (b)
          T_WILL: rx_state = S_WILL;
          T_WONT: rx_state = S_WONT;
          T_DO:   rx_state = S_DO;
          T_DONT: rx_state = S_DONT;
          T_SB:   rx_state = S_SB;
          T_SE:   rx_state = S_DATA;
          T_IAC: begin
            rx_state = S_DATA;
            fire     = 1'b1;
            r        = make_res(KIND_DATA, b, ACK_NONE, '0);
          end
          default: proto_fault(b, fire, r);
        endcase
      end
      S_WILL, S_DO, S_WONT, S_DONT: begin
        fire = 1'b1;
        r    = make_res(rx_state == S_WILL ? KIND_WILL :
                        rx_state == S_DO ? KIND_DO : KIND_REFUSE, b, ACK_NONE, '0);
        rx_state = S_DATA;
      end
      S_SB: rx_state = (b == COM_PORT_OPT) ? S_SER_CMD : S_SKIP;
      S_SKIP: if (b == T_IAC) rx_state = S_SKIP_IAC;
      S_SKIP_IAC: begin
        if (b == T_IAC) rx_state = S_SKIP;
        else if (b == T_SE) rx_state = S_DATA;
        else proto_fault(b, fire, r);
      end
      S_SER_CMD: take_serial_code(b, fire, r);
      // baud rate arrives msb first over four bytes
      S_BAUD: begin
        baud_acc = {baud_acc[23:0], b};
        baud_cnt = baud_cnt + 2'd1;
        if (baud_cnt == 2'd0) begin
          rx_state = S_SER_END;
          fire     = 1'b1;
          r        = make_res(KIND_ACK, 8'h00, ACK_BAUD, baud_acc);
        end
      end
      S_DATASIZE, S_PARITY, S_STOPSIZE, S_CONTROL, S_PURGE: begin
        fire = 1'b1;
        r    = make_res(KIND_ACK, b,
                        rx_state == S_DATASIZE ? ACK_DATASIZE :
                        rx_state == S_PARITY   ? ACK_PARITY :
                        rx_state == S_STOPSIZE ? ACK_STOPSIZE :
                        rx_state == S_CONTROL  ? ACK_CONTROL : ACK_PURGE, '0);
        rx_state = S_SER_END;
      end
      S_LINE, S_MODEM: begin
        fire     = 1'b1;
        r        = make_res(rx_state == S_LINE ? KIND_LINE : KIND_MODEM, b, ACK_NONE, '0);
        rx_state = S_SER_END;
      end
      // an iac mask value is itself quoted
      S_LSMASK, S_MSMASK: begin
        fire     = 1'b1;
        r        = make_res(KIND_ACK, b, rx_state == S_LSMASK ? ACK_LSMASK : ACK_MSMASK, '0);
        rx_state = S_SER_END;
        if (b == T_IAC) drop_next = 1'b1;
      end
      S_SER_END: begin
        if (b == T_IAC) rx_state = S_SKIP_IAC;
        else take_serial_code(b, fire, r);
      end
      default: ;
    endcase
  endfunction

  // idle cycles before the next word: mostly short, a few long
  function automatic int next_gap();
    int r;
    if (in_calm_left == 0) begin
      in_calm      = ~in_calm;
      in_calm_left = $urandom_range(10, 60);
    end else begin
      in_calm_left--;
    end
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // drive one word, wait for its acceptance, then queue what it should produce
  task automatic send_word(input logic c, input logic [7:0] b, input bit typed = 1'b0,
                           input bit t_fire = 1'b0, input res_t t_res = '0);
    int   gap;
    bit   fire;
    res_t r;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CMD_START || rx_state != S_STANDBY) n_items++;
    predict_rx(c, b, fire, r);
    if (typed) begin
      fire = t_fire;
      r    = t_res;
    end
    if (fire) pending_results = {pending_results, r};
  endtask

  // mostly well-formed telnet traffic with random content, plus noise
  task automatic run_random_traffic();
    int         pick;
    int         n;
    logic [7:0] b;
    logic [7:0] code;
    while (n_items < N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (rx_state == S_STANDBY) begin
        if (pick < 85) send_word(CMD_START, 8'($urandom_range(0, 255)));
        else send_word(CMD_BYTE, rand_byte());
      end else if (pick < 3) begin
        send_word(CMD_START, 8'($urandom_range(0, 255)));
      end else if (pick < 35) begin
        // plain data run
        n = $urandom_range(1, 6);
        repeat (n) begin
          b = ($urandom_range(0, 99) < 15) ? CH_CR : 8'($urandom_range(0, 254));
          send_word(CMD_BYTE, b);
        end
      end else if (pick < 43) begin
        send_word(CMD_BYTE, CH_CR);
        case ($urandom_range(0, 3))
          0: send_word(CMD_BYTE, CH_NUL);
          1: send_word(CMD_BYTE, CH_LF);
          2: begin
            send_word(CMD_BYTE, T_IAC);
            send_word(CMD_BYTE, T_IAC);
          end
          default: send_word(CMD_BYTE, rand_byte());
        endcase
      end else if (pick < 51) begin
        send_word(CMD_BYTE, T_IAC);
        send_word(CMD_BYTE, T_IAC);
      end else if (pick < 61) begin
        // option negotiation
        send_word(CMD_BYTE, T_IAC);
        case ($urandom_range(0, 3))
          0: send_word(CMD_BYTE, T_WILL);
          1: send_word(CMD_BYTE, T_WONT);
          2: send_word(CMD_BYTE, T_DO);
          default: send_word(CMD_BYTE, T_DONT);
        endcase
        send_word(CMD_BYTE, rand_byte());
      end else if (pick < 64) begin
        send_word(CMD_BYTE, T_IAC);
        send_word(CMD_BYTE, T_SE);
      end else if (pick < 67) begin
        send_word(CMD_BYTE, T_IAC);
        send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        // com port subnegotiation with one or more server responses
        send_word(CMD_BYTE, T_IAC);
        send_word(CMD_BYTE, T_SB);
        send_word(CMD_BYTE, COM_PORT_OPT);
        n = $urandom_range(1, 3);
        repeat (n) begin
          code = ($urandom_range(0, 9) == 0) ? rand_byte() : 8'($urandom_range(101, 112));
          send_word(CMD_BYTE, code);
          if (code == SRV_BAUD) begin
            repeat (4) send_word(CMD_BYTE, rand_byte());
          end else if (code == SRV_LSMASK || code == SRV_MSMASK) begin
            b = ($urandom_range(0, 99) < 25) ? T_IAC : 8'($urandom_range(0, 255));
            send_word(CMD_BYTE, b);
            if (b == T_IAC) send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
          end else if (code >= SRV_BAUD && code <= SRV_PURGE &&
                       code != SRV_SUSPEND && code != SRV_RESUME) begin
            send_word(CMD_BYTE, rand_byte());
          end
        end
        send_word(CMD_BYTE, T_IAC);
        if ($urandom_range(0, 9) == 0) send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
        else send_word(CMD_BYTE, T_SE);
      end else begin
        // foreign subnegotiation, skipped up to iac se
        send_word(CMD_BYTE, T_IAC);
        send_word(CMD_BYTE, T_SB);
        send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
        n = $urandom_range(0, 5);
        repeat (n) begin
          b = rand_byte();
          send_word(CMD_BYTE, b);
          if (b == T_IAC) send_word(CMD_BYTE, T_IAC);
        end
        send_word(CMD_BYTE, T_IAC);
        send_word(CMD_BYTE, T_SE);
      end
    end
  endtask

  // directed words, expected result typed in where it is obvious
  stim_row_t directed_rows [0:28] = '{
    '{CMD_BYTE,  8'h41,        1'b1, 1'b0, NO_RES},  // dropped in standby
    '{CMD_START, 8'h00,        1'b1, 1'b0, NO_RES},
    '{CMD_BYTE,  8'h00,        1'b1, 1'b1, '{KIND_DATA, 8'h00, ACK_NONE, 32'd0, 1'b1}},
    '{CMD_BYTE,  T_IAC,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_IAC,        1'b1, 1'b1, '{KIND_DATA, 8'hFF, ACK_NONE, 32'd0, 1'b1}},
    '{CMD_BYTE,  CH_CR,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  CH_NUL,       1'b1, 1'b0, NO_RES},  // cr nul collapses
    '{CMD_BYTE,  T_IAC,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_WILL,       1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  COM_PORT_OPT, 1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_IAC,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_DONT,       1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_IAC,        1'b1, 1'b1, '{KIND_REFUSE, 8'hFF, ACK_NONE, 32'd0, 1'b1}},
    '{CMD_BYTE,  T_IAC,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_SB,         1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  COM_PORT_OPT, 1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  SRV_BAUD,     1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  8'hFF,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  8'hFF,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  8'hFF,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  8'hFF,        1'b1, 1'b1, '{KIND_ACK, 8'h00, ACK_BAUD, 32'hFFFF_FFFF, 1'b1}},
    '{CMD_BYTE,  SRV_LSMASK,   1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_IAC,        1'b1, 1'b1, '{KIND_ACK, 8'hFF, ACK_LSMASK, 32'd0, 1'b1}},
    '{CMD_BYTE,  8'h55,        1'b1, 1'b0, NO_RES},  // follows a quoted mask
    '{CMD_BYTE,  SRV_SUSPEND,  1'b1, 1'b1, '{KIND_FLOW, SRV_SUSPEND, ACK_NONE, 32'd0, 1'b0}},
    '{CMD_BYTE,  T_IAC,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_SE,         1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  T_IAC,        1'b0, 1'b0, NO_RES},
    '{CMD_BYTE,  8'h00,        1'b1, 1'b1, '{KIND_ERROR, 8'h00, ACK_NONE, 32'd0, 1'b0}}
  };

  // stimulus and end of run
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_BYTE;
    in_rx_byte = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_word(directed_rows[i].cmd, directed_rows[i].rx_byte, directed_rows[i].typed,
                directed_rows[i].fire, directed_rows[i].res);
    n_items = 0;
    run_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rx_mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side stalls: random runs, with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (!out_calm && $urandom_range(0, 99) < 25)
          stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 3);
      end
      if (out_calm_left == 0) begin
        out_calm      <= ~out_calm;
        out_calm_left <= $urandom_range(20, 120);
      end else begin
        out_calm_left <= out_calm_left - 1;
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d value %0h",
               out_kind, out_value_byte);
        rx_mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          rx_mismatches++;
        end
        if (out_value_byte !== want.value_byte) begin
          $error("value_byte: expected %0h, got %0h", want.value_byte, out_value_byte);
          rx_mismatches++;
        end
        if (out_ack_code !== want.ack_code) begin
          $error("ack_code: expected %0d, got %0d", want.ack_code, out_ack_code);
          rx_mismatches++;
        end
        if (out_baud_value !== want.baud_value) begin
          $error("baud_value: expected %0h, got %0h", want.baud_value, out_baud_value);
          rx_mismatches++;
        end
        if (out_write_enabled !== want.write_enabled) begin
          $error("write_enabled: expected %0b, got %0b", want.write_enabled,
                 out_write_enabled);
          rx_mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
